// ===== rtl/core/hsl_pkg.sv =====
// Package for the HSL to RGB converter: shared types, constants and the hue ramp classifier.
`timescale 1ns / 1ps

package hsl_pkg;

  // Default number of fraction bits of saturation, lightness and opacity
  localparam int FRAC_BITS_DEF = 12;

  // Fixed port widths
  localparam int HUE_W  = 16;
  localparam int FRAC_W = 13;
  localparam int BYTE_W = 8;
  localparam int K_W    = 7;   // ramp weight, 0..60
  localparam int DEG_W  = 9;   // wrapped hue, 0..359
  localparam int NUM_CH = 3;

  // Channel order inside the lane arrays
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Hue offset that makes every input hue positive (a multiple of 360)
  localparam int HUE_OFFSET = 33120;
  // Reciprocal of 360 for the modulo: q = (x * RECIP_360) >> RECIP_SHIFT
  localparam int RECIP_360   = 93207;
  localparam int RECIP_SHIFT = 25;

  // Classified transaction handed from the front to the back
  typedef struct packed {
    logic [NUM_CH-1:0][K_W-1:0] k;     // ramp weight per channel
    logic [FRAC_W-1:0]          sat;   // clamped saturation
    logic [FRAC_W-1:0]          light; // clamped lightness
    logic [FRAC_W-1:0]          opac;  // clamped opacity
  } hsl_item_t;

  // Ramp weight k of a wrapped hue: value = m1 + (m2 - m1) * k / 60
  function automatic logic [K_W-1:0] ramp_k(input logic [DEG_W-1:0] h);
    logic [K_W-1:0] k;
    if (h < DEG_W'(60)) begin
      k = K_W'(h);
    end else if (h < DEG_W'(180)) begin
      k = K_W'(60);
    end else if (h < DEG_W'(240)) begin
      k = K_W'(DEG_W'(240) - h);
    end else begin
      k = '0;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/hsl_front.sv =====
// Front end: hue wrap modulo 360, channel ramp classification and fraction clamping.
`timescale 1ns / 1ps

module hsl_front
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     stall_i,
  input  logic signed [HUE_W-1:0]  hue_degrees_i,
  input  logic        [FRAC_W-1:0] saturation_i,
  input  logic        [FRAC_W-1:0] lightness_i,
  input  logic        [FRAC_W-1:0] opacity_i,
  output logic                     item_valid_o,
  output hsl_item_t                item_o
);

  localparam int XW = HUE_W + 1;
  localparam int PW = 2 * XW;
  localparam int CW = FRAC_BITS + FRAC_W + 1;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] v);
    logic [FRAC_W-1:0] r;
    if (CW'(v) > ONE) begin
      r = FRAC_W'(ONE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Stage 1: offset hue, reciprocal product, clamps
  logic              f1_vld_q;
  logic [XW-1:0]     x_q;
  logic [PW-1:0]     prod_q;
  logic [FRAC_W-1:0] sat_q, light_q, opac_q;
  logic signed [XW:0] xs;
  logic [XW-1:0]     x_d;

  assign xs  = (XW+1)'(hue_degrees_i) + (XW+1)'(HUE_OFFSET);
  assign x_d = xs[XW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (!stall_i) begin
      f1_vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i && accept_i) begin
      x_q     <= x_d;
      prod_q  <= PW'(x_d) * PW'(RECIP_360);
      sat_q   <= clamp_frac(saturation_i);
      light_q <= clamp_frac(lightness_i);
      opac_q  <= clamp_frac(opacity_i);
    end
  end

  // Stage 2: remainder and per-channel ramp weights
  logic [DEG_W-1:0] quo;
  logic [XW-1:0]    qx;
  logic [XW-1:0]    rem;
  logic [DEG_W-1:0] hg;
  logic [DEG_W:0]   hr_sum, hb_sum;
  logic [DEG_W:0]   hr, hb;

  assign quo = prod_q[RECIP_SHIFT+DEG_W-1:RECIP_SHIFT];
  // q * 360 = q * (256 + 64 + 32 + 8)
  assign qx  = (XW'(quo) << 8) + (XW'(quo) << 6) + (XW'(quo) << 5) + (XW'(quo) << 3);
  assign rem = x_q - qx;
  assign hg  = rem[DEG_W-1:0];

  assign hr_sum = (DEG_W+1)'(hg) + (DEG_W+1)'(120);
  assign hb_sum = (DEG_W+1)'(hg) + (DEG_W+1)'(240);
  assign hr = (hr_sum >= (DEG_W+1)'(360)) ? hr_sum - (DEG_W+1)'(360) : hr_sum;
  assign hb = (hb_sum >= (DEG_W+1)'(360)) ? hb_sum - (DEG_W+1)'(360) : hb_sum;

  logic      f2_vld_q;
  hsl_item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_vld_q <= 1'b0;
    end else if (!stall_i) begin
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i && f1_vld_q) begin
      item_q.k[CH_RED]   <= ramp_k(hr[DEG_W-1:0]);
      item_q.k[CH_GREEN] <= ramp_k(hg);
      item_q.k[CH_BLUE]  <= ramp_k(hb[DEG_W-1:0]);
      item_q.sat         <= sat_q;
      item_q.light       <= light_q;
      item_q.opac        <= opac_q;
    end
  end

  assign item_valid_o = f2_vld_q && !stall_i;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/hsl_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module hsl_queue
  import hsl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hsl_item_t data_i,
  output logic      full_o,
  output logic      pop_o,
  output hsl_item_t data_o
);

  localparam int DEPTH = 2;

  hsl_item_t  mem_q [DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  // The back end never stalls, so any held entry leaves at once
  assign pop     = (count_q != 2'd0);
  assign full_o  = (count_q == 2'(DEPTH));
  assign count_d = count_q + 2'(push_i) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign pop_o  = pop;
  assign data_o = mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/hsl_back.sv =====
// Back end: m1/m2 formation, hue ramp evaluation, clamp and byte scaling.
`timescale 1ns / 1ps

module hsl_back
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  hsl_item_t                        item_i,
  output logic                             valid_o,
  output logic [NUM_CH-1:0][BYTE_W-1:0]    chan_o,
  output logic [BYTE_W-1:0]                alpha_o
);

  localparam int F  = FRAC_BITS;
  localparam int CW = F + FRAC_W + 1;   // fraction compares and alpha product
  localparam int PW = 2 * FRAC_W;       // l * s
  localparam int WW = 2 * F + 3;        // m2 intermediate, scaled by ONE^2
  localparam int MW = 2 * F + 1;        // m1 and span
  localparam int VW = 2 * F + 6;        // ramp value, scaled by 60 * ONE^2
  localparam int BW = VW + 5;           // ramp value times 17
  localparam logic [VW-1:0] FULL = VW'(60) << (2 * F);

  // Stage 1: l * s, branch select, alpha byte
  logic                      b1_vld_q;
  logic [PW-1:0]             p_q;
  logic                      low_q;
  logic [FRAC_W-1:0]         s_q, l_q;
  logic [NUM_CH-1:0][K_W-1:0] k1_q;
  logic [BYTE_W-1:0]         a1_q;
  logic [CW-1:0]             a_prod;

  assign a_prod = (CW'(item_i.opac) << 8) - CW'(item_i.opac);

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p_q   <= PW'(item_i.light) * PW'(item_i.sat);
      low_q <= (CW'(item_i.light) << 1) <= (CW'(1) << F);
      s_q   <= item_i.sat;
      l_q   <= item_i.light;
      k1_q  <= item_i.k;
      a1_q  <= a_prod[F+BYTE_W-1:F];
    end
  end

  // Stage 2: m2 = l*(1+s) or l+s-l*s, m1 = 2l - m2
  logic [WW-1:0]             l_one, s_one, p_w, m2, m1;
  logic [MW-1:0]             m1_q, span_q;
  logic [NUM_CH-1:0][K_W-1:0] k2_q;
  logic [BYTE_W-1:0]         a2_q;
  logic                      b2_vld_q;

  assign l_one = WW'(l_q) << F;
  assign s_one = WW'(s_q) << F;
  assign p_w   = WW'(p_q);
  assign m2    = low_q ? l_one + p_w : l_one + s_one - p_w;
  assign m1    = (l_one << 1) - m2;

  always_ff @(posedge clk_i) begin
    if (b1_vld_q) begin
      m1_q   <= MW'(m1);
      span_q <= MW'(m2 - m1);
      k2_q   <= k1_q;
      a2_q   <= a1_q;
    end
  end

  // Stage 3: ramp value per channel, clamped to 60 * ONE^2
  logic [NUM_CH-1:0][VW-1:0] v;
  logic [NUM_CH-1:0][VW-1:0] v_q;
  logic [VW-1:0]             m1x60;
  logic [BYTE_W-1:0]         a3_q;
  logic                      b3_vld_q;

  assign m1x60 = (VW'(m1_q) << 6) - (VW'(m1_q) << 2);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      v[c] = m1x60 + VW'(span_q) * VW'(k2_q[c]);
      if (v[c] > FULL) begin
        v[c] = FULL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b2_vld_q) begin
      v_q  <= v;
      a3_q <= a2_q;
    end
  end

  // Stage 4: byte = v * 255 / (60 * ONE^2) = (v * 17) >> (2F + 2)
  logic [NUM_CH-1:0][BW-1:0]     bx;
  logic [NUM_CH-1:0][BYTE_W-1:0] chan_q;
  logic [BYTE_W-1:0]             a4_q;
  logic                          b4_vld_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      bx[c] = (BW'(v_q[c]) << 4) + BW'(v_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b3_vld_q) begin
      for (int c = 0; c < NUM_CH; c++) begin
        chan_q[c] <= bx[c][2*F+2+BYTE_W-1:2*F+2];
      end
      a4_q <= a3_q;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
      b4_vld_q <= 1'b0;
    end else begin
      b1_vld_q <= valid_i;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
      b4_vld_q <= b3_vld_q;
    end
  end

  assign valid_o = b4_vld_q;
  assign chan_o  = chan_q;
  assign alpha_o = a4_q;

endmodule

// ===== rtl/core/hsl_to_rgb_converter_unit.sv =====
// HSL to RGB converter (CSS3 color model), top level.
// Throughput: one transaction per cycle; a front pipeline, a two-entry queue and a
// four-stage back pipeline each take one transaction per cycle.
// Results leave on a one-cycle strobe; the receiver cannot stall, so busy_o stays low.
// Reset (rst_ni, asynchronous, active low) clears all valid bits and the queue.
`timescale 1ns / 1ps

module hsl_to_rgb_converter_unit
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [HUE_W-1:0]  hue_degrees_i,
  input  logic        [FRAC_W-1:0] saturation_i,
  input  logic        [FRAC_W-1:0] lightness_i,
  input  logic        [FRAC_W-1:0] opacity_i,
  output logic                     result_valid_o,
  output logic        [BYTE_W-1:0] red_o,
  output logic        [BYTE_W-1:0] green_o,
  output logic        [BYTE_W-1:0] blue_o,
  output logic        [BYTE_W-1:0] alpha_byte_o
);

  logic                          q_full;
  logic                          push;
  logic                          pop;
  hsl_item_t                     front_item;
  hsl_item_t                     q_item;
  logic [NUM_CH-1:0][BYTE_W-1:0] chan;

  assign busy_o = q_full;

  // Front end
  hsl_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (start_i && !q_full),
    .stall_i      (q_full),
    .hue_degrees_i(hue_degrees_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .opacity_i    (opacity_i),
    .item_valid_o (push),
    .item_o       (front_item)
  );

  // Decoupling queue
  hsl_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(front_item),
    .full_o(q_full),
    .pop_o (pop),
    .data_o(q_item)
  );

  // Back end
  hsl_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(pop),
    .item_i (q_item),
    .valid_o(result_valid_o),
    .chan_o (chan),
    .alpha_o(alpha_byte_o)
  );

  assign red_o   = chan[CH_RED];
  assign green_o = chan[CH_GREEN];
  assign blue_o  = chan[CH_BLUE];

endmodule
